// File: rtl/vn3_pkg.sv
// Shared constants, types and helpers for the 3D vector normalizer.
// Depends on nothing; every other file imports it.
`default_nettype none
package vn3_pkg;

    localparam int CW        = 32;           // input component width
    localparam int FB        = 16;           // input fraction bits
    localparam int OUT_W     = 32;           // Q1.30 output width
    localparam int OUT_FRAC  = 30;
    localparam int LIM_W     = 16;
    localparam int SUM_W     = 2 * CW + 2;   // sum of three squares
    localparam int RW        = SUM_W / 2;    // integer square root width
    localparam int REM_W     = RW + 2;       // root remainder width
    localparam int DREM_W    = RW + 1;       // divider remainder width
    localparam int Q_W       = OUT_FRAC + 1; // quotient bits, value <= 2^30
    localparam int SQRT_STAGES = RW;
    localparam int DIV_STAGES  = Q_W;

    typedef logic [CW-1:0]    mag_t;
    typedef logic [OUT_W-1:0] out_t;

    typedef struct packed {
        logic [2:0]     neg;
        mag_t [2:0]     mag;
        logic           unit_len;
        logic           tiny;
        logic           zero_root;
    } side_t;

    // Shift into Q1.30, saturated to one.
    function automatic out_t format_only(input logic neg, input mag_t mag);
        out_t v;
        if (mag > mag_t'(1) << FB)
            v = out_t'(1) << OUT_FRAC;
        else
            v = out_t'(mag) << (OUT_FRAC - FB);
        return neg ? out_t'(-v) : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/vn3_if.sv
// Valid/ready channel interfaces for the vector normalizer.
// Depends on vn3_pkg.
`default_nettype none
interface vn3_in_if;
    import vn3_pkg::*;
    logic valid;
    logic ready;
    logic signed [CW-1:0] comp_x;
    logic signed [CW-1:0] comp_y;
    logic signed [CW-1:0] comp_z;
    modport source (output valid, comp_x, comp_y, comp_z, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn3_out_if;
    import vn3_pkg::*;
    logic valid;
    logic ready;
    logic signed [OUT_W-1:0] unit_x;
    logic signed [OUT_W-1:0] unit_y;
    logic signed [OUT_W-1:0] unit_z;
    logic passed_through;
    modport source (output valid, unit_x, unit_y, unit_z, passed_through, input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, passed_through, output ready);
endinterface
`default_nettype wire

// File: rtl/vn3_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on vn3_pkg.
`default_nettype none
module vn3_sqrt (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [vn3_pkg::SUM_W-1:0] in_s,
    input  wire vn3_pkg::side_t        in_side,
    output logic                       out_valid,
    output logic [vn3_pkg::RW-1:0]     out_root,
    output vn3_pkg::side_t             out_side
);
    import vn3_pkg::*;

    logic [SQRT_STAGES-1:0] v_reg;
    logic [REM_W-1:0] rem_reg  [SQRT_STAGES];
    logic [RW-1:0]    root_reg [SQRT_STAGES];
    logic [SUM_W-1:0] s_reg    [SQRT_STAGES];
    side_t            side_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [REM_W-1:0] p_rem;
        logic [RW-1:0]    p_root;
        logic [SUM_W-1:0] p_s;
        side_t            p_side;
        logic             p_v;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_s    = in_s;
            assign p_side = in_side;
            assign p_v    = in_valid;
        end else begin : g_rest
            assign p_rem  = rem_reg[k-1];
            assign p_root = root_reg[k-1];
            assign p_s    = s_reg[k-1];
            assign p_side = side_reg[k-1];
            assign p_v    = v_reg[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh = {p_rem[REM_W-3:0], p_s[SUM_W-1 -: 2]};
        assign trial  = (REM_W'(p_root) << 2) | REM_W'(1);
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= p_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {p_root[RW-2:0], ge};
                s_reg[k]    <= p_s << 2;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];
endmodule
`default_nettype wire

// File: rtl/vn3_div.sv
// Pipelined restoring divider, three lanes, floor(m * 2^30 / r) for m <= r.
// Depends on vn3_pkg.
`default_nettype none
module vn3_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [vn3_pkg::RW-1:0] in_r,
    input  wire logic [vn3_pkg::RW-1:0] in_m [3],
    input  wire vn3_pkg::side_t        in_side,
    output logic                       out_valid,
    output logic [vn3_pkg::Q_W-1:0]    out_q [3],
    output vn3_pkg::side_t             out_side
);
    import vn3_pkg::*;

    logic [DIV_STAGES-1:0] v_reg;
    logic [DREM_W-1:0] rem_reg  [DIV_STAGES][3];
    logic [Q_W-1:0]    q_reg    [DIV_STAGES][3];
    logic [RW-1:0]     r_reg    [DIV_STAGES];
    side_t             side_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DREM_W-1:0] p_rem [3];
        logic [Q_W-1:0]    p_q   [3];
        logic [RW-1:0]     p_r;
        side_t             p_side;
        logic              p_v;

        if (k == 0) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign p_rem[j] = DREM_W'(in_m[j]);
                assign p_q[j]   = '0;
            end
            assign p_r    = in_r;
            assign p_side = in_side;
            assign p_v    = in_valid;
        end else begin : g_rest
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign p_rem[j] = rem_reg[k-1][j];
                assign p_q[j]   = q_reg[k-1][j];
            end
            assign p_r    = r_reg[k-1];
            assign p_side = side_reg[k-1];
            assign p_v    = v_reg[k-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane_step
            logic [DREM_W-1:0] t;
            logic              ge;
            // integer quotient bit first, fraction bits after
            assign t  = (k == 0) ? p_rem[j] : p_rem[j] << 1;
            assign ge = t >= DREM_W'(p_r);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][j] <= ge ? t - DREM_W'(p_r) : t;
                    q_reg[k][j]   <= {p_q[j][Q_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= p_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= p_r;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
endmodule
`default_nettype wire

// File: rtl/vector_normalize_3d_core.sv
// Top level of the 3D vector normalizer: front end, root, divide, output.
// Depends on vn3_pkg, vn3_if, vn3_sqrt and vn3_div.
//
// Takes one signed Q16.16 vector per cycle while the output is not stalled and
// returns its unit vector in signed Q1.30, truncated toward zero, one result per
// input item. The stages are three front-end stages (magnitude, squares, sum and
// compares), one square-root stage per root bit, a clamp stage, one divider
// stage per quotient bit, and the output register. A vector of exact unit
// length is only reformatted; one whose magnitude is at or below the limit
// written through cfg_wdata passes through saturated with passed_through set. The
// whole pipeline advances together and holds while the output is stalled.
`default_nettype none
module vector_normalize_3d_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    vn3_in_if.sink           vec_in,
    vn3_out_if.source        vec_out,
    input  wire logic        cfg_we,
    input  wire logic [vn3_pkg::LIM_W-1:0] cfg_wdata
);
    import vn3_pkg::*;

    logic en;
    logic [LIM_W-1:0] limit_reg;

    logic             a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    side_t            a_side_reg, b_side_reg, c_side_reg, d_side_reg;
    logic [2*CW-1:0]  sq_reg [3];
    logic [2*LIM_W-1:0] limsq_reg;
    logic [SUM_W-1:0] s_reg;
    logic [SUM_W-1:0] sum;
    logic [RW-1:0]    d_r_reg;
    logic [RW-1:0]    d_m_reg [3];
    logic             sq_v;
    logic [RW-1:0]    sq_root;
    side_t            sq_side;
    logic             dv_v;
    logic [Q_W-1:0]   dv_q [3];
    side_t            dv_side;
    out_t             unit_reg [3];
    logic             pass_reg;
    logic signed [CW-1:0] comp [3];

    assign en           = !e_v_reg || vec_out.ready;
    assign vec_in.ready = en;
    assign comp[0] = vec_in.comp_x;
    assign comp[1] = vec_in.comp_y;
    assign comp[2] = vec_in.comp_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= vec_in.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= sq_v;
            e_v_reg <= dv_v;
        end
    end

    assign sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitude; the most negative code maps onto itself
            for (int j = 0; j < 3; j++)
            begin
                a_side_reg.neg[j] <= comp[j][CW-1];
                a_side_reg.mag[j] <= comp[j][CW-1] ? mag_t'(-comp[j]) : mag_t'(comp[j]);
            end
            a_side_reg.unit_len  <= 1'b0;
            a_side_reg.tiny      <= 1'b0;
            a_side_reg.zero_root <= 1'b0;

            for (int j = 0; j < 3; j++)
                sq_reg[j] <= (2*CW)'(a_side_reg.mag[j]) * (2*CW)'(a_side_reg.mag[j]);
            limsq_reg  <= (2*LIM_W)'(limit_reg) * (2*LIM_W)'(limit_reg);
            b_side_reg <= a_side_reg;

            s_reg                <= sum;
            c_side_reg.neg       <= b_side_reg.neg;
            c_side_reg.mag       <= b_side_reg.mag;
            c_side_reg.zero_root <= b_side_reg.zero_root;
            c_side_reg.unit_len  <= sum == (SUM_W'(1) << (2 * FB));
            c_side_reg.tiny      <= sum <= SUM_W'(limsq_reg);

            // clamp each magnitude to the root before dividing
            d_r_reg              <= sq_root;
            for (int j = 0; j < 3; j++)
                d_m_reg[j] <= (RW'(sq_side.mag[j]) > sq_root) ? sq_root : RW'(sq_side.mag[j]);
            d_side_reg.neg       <= sq_side.neg;
            d_side_reg.mag       <= sq_side.mag;
            d_side_reg.unit_len  <= sq_side.unit_len;
            d_side_reg.tiny      <= sq_side.tiny;
            d_side_reg.zero_root <= sq_root == '0;

            for (int j = 0; j < 3; j++)
            begin
                if (dv_side.unit_len || dv_side.tiny)
                    unit_reg[j] <= format_only(dv_side.neg[j], dv_side.mag[j]);
                else if (dv_side.zero_root)
                    unit_reg[j] <= '0;
                else
                    unit_reg[j] <= dv_side.neg[j] ? out_t'(-OUT_W'(dv_q[j]))
                                                  : OUT_W'(dv_q[j]);
            end
            pass_reg <= !dv_side.unit_len && dv_side.tiny;
        end
    end

    vn3_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_v_reg),
        .in_s      (s_reg),
        .in_side   (c_side_reg),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    vn3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_v_reg),
        .in_r      (d_r_reg),
        .in_m      (d_m_reg),
        .in_side   (d_side_reg),
        .out_valid (dv_v),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    assign vec_out.valid          = e_v_reg;
    assign vec_out.unit_x         = unit_reg[0];
    assign vec_out.unit_y         = unit_reg[1];
    assign vec_out.unit_z         = unit_reg[2];
    assign vec_out.passed_through = pass_reg;
endmodule
`default_nettype wire

// File: rtl/vn3_checker.sv
// Port-level checks for the vector normalizer, bound to the top level.
// Depends on vn3_pkg and vector_normalize_3d_core.
`default_nettype none
module vn3_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [vn3_pkg::OUT_W-1:0] unit_x,
    input wire logic [vn3_pkg::OUT_W-1:0] unit_y,
    input wire logic [vn3_pkg::OUT_W-1:0] unit_z
);
    import vn3_pkg::*;

    localparam logic signed [OUT_W-1:0] One = OUT_W'(1) << OUT_FRAC;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(unit_x) && $stable(unit_y) && $stable(unit_z))
        else $error("result item changed while stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a blocked result item");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(unit_x) <= One && $signed(unit_x) >= -One &&
                       $signed(unit_y) <= One && $signed(unit_y) >= -One &&
                       $signed(unit_z) <= One && $signed(unit_z) >= -One))
        else $error("unit component outside Q1.30 unit range");
endmodule

bind vector_normalize_3d_core vn3_checker u_vn3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vec_in.ready),
    .out_valid (vec_out.valid),
    .out_ready (vec_out.ready),
    .unit_x    (vec_out.unit_x),
    .unit_y    (vec_out.unit_y),
    .unit_z    (vec_out.unit_z)
);
`default_nettype wire
